FILE: hw/rtl/bcip_pkg.sv
// Shared types, widths and helpers for the box-center-in-polygon block.
// Used by bcip_div, bcip_cell and box_center_in_polygon; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package bcip_pkg;

   // Polygon and fixed-point geometry
   localparam int MAX_VERTICES  = 16;
   localparam int FRACTION_BITS = 16;
   localparam int MIN_VERTS     = 3;

   localparam int COORD_W = 16;                        // vertex coordinate
   localparam int PIX_W   = 13;                        // pixel position / size
   localparam int VIDX_W  = 4;                         // vertex slot field
   localparam int VCNT_W  = 5;                         // vertex_count register
   localparam int CNT_W   = $clog2(MAX_VERTICES + 1);  // clipped vertex count
   localparam int IDX_W   = $clog2(MAX_VERTICES);      // cell index

   // Center division: ((2*pos + size) << FRACTION_BITS) / (2*frame)
   localparam int SUM_W   = PIX_W + 2;
   localparam int DEN_W   = PIX_W + 1;
   localparam int NUM_W   = SUM_W + FRACTION_BITS;
   localparam int DIV_W   = NUM_W + (NUM_W % 2);       // even, two bits per cycle
   localparam int DIV_CYC = DIV_W / 2;
   localparam int DCNT_W  = $clog2(DIV_CYC);
   localparam int CX_W    = NUM_W;                     // center coordinate

   // Edge test products
   localparam int DIFF_W = CX_W + 1;
   localparam int DY_W   = COORD_W + 1;
   localparam int PROD_W = DIFF_W + DY_W;

   // Configuration port
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = PIX_W;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_FRAME_WIDTH  = 2'd0,
      REG_FRAME_HEIGHT = 2'd1,
      REG_VERTEX_COUNT = 2'd2
   } reg_index_type;

   typedef enum logic {
      OP_LOAD  = 1'b0,
      OP_QUERY = 1'b1
   } opcode_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_DIVIDE,
      S_WALK,
      S_EMIT
   } state_type;

   // Data handed from cell to cell. The products of an edge are resolved
   // one cell later, so each compare sits behind a product register.
   typedef struct packed {
      logic [CX_W-1:0]           cx;
      logic [CX_W-1:0]           cy;
      logic [COORD_W-1:0]        px;
      logic [COORD_W-1:0]        py;
      logic                      flag;
      logic                      pend;
      logic                      pneg;
      logic signed [PROD_W-1:0]  lhs;
      logic signed [PROD_W-1:0]  rhs;
   } tok_type;

   typedef struct packed {
      logic wr;   // load this cell's vertex
      logic en;   // cell lies within the vertex count
   } cell_ctl_type;

   function automatic logic edge_cross(input logic pneg,
                                       input logic signed [PROD_W-1:0] lhs,
                                       input logic signed [PROD_W-1:0] rhs);
      return pneg ? (lhs > rhs) : (lhs < rhs);
   endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/bcip_div.sv
// Iterative unsigned divider, two quotient bits per cycle, for the box center.
// Depends on bcip_pkg for widths.
`timescale 1ns / 1ps
`default_nettype none

module bcip_div (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         start,
   input  wire logic [bcip_pkg::NUM_W-1:0]   dividend,
   input  wire logic [bcip_pkg::DEN_W-1:0]   divisor,
   output logic                              done,
   output logic [bcip_pkg::CX_W-1:0]         quotient
);

   logic [bcip_pkg::DIV_W-1:0]  quo_ff, quo_in;
   logic [bcip_pkg::DEN_W-1:0]  rem_ff, rem_in;
   logic [bcip_pkg::DEN_W-1:0]  den_ff;
   logic [bcip_pkg::DCNT_W-1:0] cnt_ff;
   logic                        busy_ff;
   logic                        done_ff;

   always_comb begin
      logic [bcip_pkg::DEN_W:0] trial;
      quo_in = quo_ff;
      rem_in = rem_ff;
      for (int s = 0; s < 2; s++) begin
         trial  = {rem_in, quo_in[bcip_pkg::DIV_W-1]};
         quo_in = {quo_in[bcip_pkg::DIV_W-2:0], 1'b0};
         if (trial >= {1'b0, den_ff}) begin
            trial     = trial - {1'b0, den_ff};
            quo_in[0] = 1'b1;
         end
         rem_in = trial[bcip_pkg::DEN_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= busy_ff && !start
                 && (cnt_ff == bcip_pkg::DCNT_W'(bcip_pkg::DIV_CYC - 1));
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == bcip_pkg::DCNT_W'(bcip_pkg::DIV_CYC - 1)) begin
               busy_ff <= 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         quo_ff <= bcip_pkg::DIV_W'(dividend);
         rem_ff <= '0;
         den_ff <= divisor;
      end else if (busy_ff) begin
         quo_ff <= quo_in;
         rem_ff <= rem_in;
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff[bcip_pkg::CX_W-1:0];

endmodule

`default_nettype wire

FILE: hw/rtl/bcip_cell.sv
// One polygon cell: holds one vertex, resolves the previous edge's crossing
// and forms the products for its own edge. Depends on bcip_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bcip_cell (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire bcip_pkg::cell_ctl_type         ctl,
   input  wire logic [bcip_pkg::COORD_W-1:0]   wr_x,
   input  wire logic [bcip_pkg::COORD_W-1:0]   wr_y,
   input  wire logic                           in_vld,
   input  wire bcip_pkg::tok_type              in_tok,
   output logic                                out_vld,
   output bcip_pkg::tok_type                   out_tok,
   output logic [bcip_pkg::COORD_W-1:0]        vx,
   output logic [bcip_pkg::COORD_W-1:0]        vy
);

   logic [bcip_pkg::COORD_W-1:0] vx_ff, vy_ff;
   logic                         vld_ff;
   bcip_pkg::tok_type            tok_ff, tok_in;

   logic                               above_i, above_j;
   logic signed [bcip_pkg::DIFF_W-1:0] dcx, dcy;
   logic signed [bcip_pkg::DY_W-1:0]   dy, dx;
   logic signed [bcip_pkg::PROD_W-1:0] lhs, rhs;

   // This cell is vertex i; the token carries the previous vertex j.
   assign above_i = bcip_pkg::CX_W'(vy_ff) > in_tok.cy;
   assign above_j = bcip_pkg::CX_W'(in_tok.py) > in_tok.cy;
   assign dy  = $signed({1'b0, in_tok.py}) - $signed({1'b0, vy_ff});
   assign dx  = $signed({1'b0, in_tok.px}) - $signed({1'b0, vx_ff});
   assign dcx = $signed({1'b0, in_tok.cx}) - $signed(bcip_pkg::DIFF_W'(vx_ff));
   assign dcy = $signed({1'b0, in_tok.cy}) - $signed(bcip_pkg::DIFF_W'(vy_ff));
   assign lhs = dcx * dy;
   assign rhs = dx * dcy;

   always_comb begin
      tok_in      = in_tok;
      tok_in.flag = in_tok.flag
                  ^ (in_tok.pend & bcip_pkg::edge_cross(in_tok.pneg, in_tok.lhs,
                                                        in_tok.rhs));
      tok_in.pend = ctl.en & (above_i != above_j);
      tok_in.pneg = dy[bcip_pkg::DY_W-1];
      tok_in.lhs  = lhs;
      tok_in.rhs  = rhs;
      if (ctl.en) begin
         tok_in.px = vx_ff;
         tok_in.py = vy_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= in_vld;
      end
   end

   always_ff @(posedge clock) begin
      tok_ff <= tok_in;
      if (ctl.wr) begin
         vx_ff <= wr_x;
         vy_ff <= wr_y;
      end
   end

   assign out_vld = vld_ff;
   assign out_tok = tok_ff;
   assign vx      = vx_ff;
   assign vy      = vy_ff;

endmodule

`default_nettype wire

FILE: hw/rtl/box_center_in_polygon.sv
// Top level of the box-center-in-polygon block: configuration, control,
// center dividers and the vertex cell chain. Depends on bcip_pkg, bcip_div, bcip_cell.
`timescale 1ns / 1ps
`default_nettype none

// A load transaction writes one vertex into its cell, gives no response, and
// leaves the block ready for the next transaction. A query transaction gives
// exactly one response: when the frame size is zero or fewer than three
// vertices are in use, the query goes straight to the emit state, which loads
// the response register once it is free and then returns to idle. Otherwise
// the two dividers that form the box center run at two quotient bits per
// cycle, the center is handed to the chain, the query walks the 16-cell vertex
// chain at one cell per cycle, the last edge is resolved into the result
// register and the response register is loaded once it is free; the block
// then returns to idle for the next transaction. One query is in flight at a
// time; a finished flag waits in the response register while the next
// transaction is accepted, and a query that finishes while that register is
// still held waits for it. Vertex slots that are in use must have been loaded
// before a query.
module box_center_in_polygon (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output logic                                   req_ready,
   input  wire logic                              req_opcode,
   input  wire logic [bcip_pkg::VIDX_W-1:0]       req_vertex_index,
   input  wire logic [bcip_pkg::COORD_W-1:0]      req_vertex_x,
   input  wire logic [bcip_pkg::COORD_W-1:0]      req_vertex_y,
   input  wire logic [bcip_pkg::PIX_W-1:0]        req_box_x,
   input  wire logic [bcip_pkg::PIX_W-1:0]        req_box_y,
   input  wire logic [bcip_pkg::PIX_W-1:0]        req_box_w,
   input  wire logic [bcip_pkg::PIX_W-1:0]        req_box_h,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_ready,
   output logic                                   rsp_inside_res,
   input  wire logic                              csr_wr_en,
   input  wire logic [bcip_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire logic [bcip_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   // Configuration
   logic [bcip_pkg::PIX_W-1:0]  frame_width_ff;
   logic [bcip_pkg::PIX_W-1:0]  frame_height_ff;
   logic [bcip_pkg::VCNT_W-1:0] vertex_count_ff;

   // Control
   bcip_pkg::state_type state_ff, state_in;
   logic                res_ff, res_in;
   logic                rsp_valid_ff, rsp_inside_ff;

   logic req_acc, is_query, is_load, early_zero;
   logic div_start, chain_inject, rsp_load, res_walk, res_zero;

   logic [bcip_pkg::CNT_W-1:0] n_use;
   logic [bcip_pkg::IDX_W-1:0] last_idx;

   // Dividers
   logic [bcip_pkg::SUM_W-1:0] sum_x, sum_y;
   logic                       done_x, done_y, div_done;
   logic [bcip_pkg::CX_W-1:0]  cx, cy;

   // Cell chain
   logic                         chain_vld [bcip_pkg::MAX_VERTICES+1];
   bcip_pkg::tok_type            chain_tok [bcip_pkg::MAX_VERTICES+1];
   logic [bcip_pkg::COORD_W-1:0] cell_x [bcip_pkg::MAX_VERTICES];
   logic [bcip_pkg::COORD_W-1:0] cell_y [bcip_pkg::MAX_VERTICES];
   logic [bcip_pkg::MAX_VERTICES-1:0] vld_vec;
   bcip_pkg::tok_type            head_tok;
   bcip_pkg::tok_type            last_tok;
   logic                         final_flag;

   // ---------------------------------------------------------------- config
   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff  <= '0;
         frame_height_ff <= '0;
         vertex_count_ff <= '0;
      end else if (csr_wr_en) begin
         case (csr_index)
            bcip_pkg::REG_FRAME_WIDTH:  frame_width_ff  <= csr_wdata;
            bcip_pkg::REG_FRAME_HEIGHT: frame_height_ff <= csr_wdata;
            bcip_pkg::REG_VERTEX_COUNT:
               vertex_count_ff <= csr_wdata[bcip_pkg::VCNT_W-1:0];
            default: ;  // unknown index: drop the write
         endcase
      end
   end

   assign n_use = (bcip_pkg::CNT_W'(vertex_count_ff) > bcip_pkg::CNT_W'(bcip_pkg::MAX_VERTICES))
                ? bcip_pkg::CNT_W'(bcip_pkg::MAX_VERTICES)
                : bcip_pkg::CNT_W'(vertex_count_ff);
   assign last_idx = bcip_pkg::IDX_W'(n_use - 1'b1);

   assign early_zero = (n_use < bcip_pkg::CNT_W'(bcip_pkg::MIN_VERTS))
                     || (frame_width_ff == '0) || (frame_height_ff == '0);

   // ---------------------------------------------------------------- control
   assign req_ready = (state_ff == bcip_pkg::S_IDLE);
   assign req_acc   = req_valid && req_ready;
   assign is_query  = (req_opcode == bcip_pkg::OP_QUERY);
   assign is_load   = (req_opcode == bcip_pkg::OP_LOAD);
   assign div_done  = done_x && done_y;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         bcip_pkg::S_IDLE:
            if (req_acc && is_query) begin
               state_in = early_zero ? bcip_pkg::S_EMIT : bcip_pkg::S_DIVIDE;
            end
         bcip_pkg::S_DIVIDE:
            if (div_done) begin
               state_in = bcip_pkg::S_WALK;
            end
         bcip_pkg::S_WALK:
            if (chain_vld[bcip_pkg::MAX_VERTICES]) begin
               state_in = bcip_pkg::S_EMIT;
            end
         bcip_pkg::S_EMIT:
            if (!rsp_valid_ff || rsp_ready) begin
               state_in = bcip_pkg::S_IDLE;
            end
         default: state_in = bcip_pkg::S_IDLE;
      endcase
   end

   always_comb begin
      div_start    = 1'b0;
      chain_inject = 1'b0;
      rsp_load     = 1'b0;
      res_walk     = 1'b0;
      res_zero     = 1'b0;
      case (state_ff)
         bcip_pkg::S_IDLE: begin
            div_start = req_acc && is_query && !early_zero;
            res_zero  = req_acc && is_query && early_zero;
         end
         bcip_pkg::S_DIVIDE: chain_inject = div_done;
         bcip_pkg::S_WALK:   res_walk     = chain_vld[bcip_pkg::MAX_VERTICES];
         bcip_pkg::S_EMIT:   rsp_load     = !rsp_valid_ff || rsp_ready;
         default: ;
      endcase
   end

   always_comb begin
      res_in = res_ff;
      if (res_zero) begin
         res_in = 1'b0;
      end else if (res_walk) begin
         res_in = final_flag;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= bcip_pkg::S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      res_ff <= res_in;
      if (rsp_load) begin
         rsp_inside_ff <= res_ff;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_inside_res = rsp_inside_ff;

   // ---------------------------------------------------------------- center
   assign sum_x = bcip_pkg::SUM_W'({req_box_x, 1'b0}) + bcip_pkg::SUM_W'(req_box_w);
   assign sum_y = bcip_pkg::SUM_W'({req_box_y, 1'b0}) + bcip_pkg::SUM_W'(req_box_h);

   bcip_div u_div_x (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend ({sum_x, bcip_pkg::FRACTION_BITS'(0)}),
      .divisor  ({frame_width_ff, 1'b0}),
      .done     (done_x),
      .quotient (cx)
   );

   bcip_div u_div_y (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend ({sum_y, bcip_pkg::FRACTION_BITS'(0)}),
      .divisor  ({frame_height_ff, 1'b0}),
      .done     (done_y),
      .quotient (cy)
   );

   // ---------------------------------------------------------------- chain
   // The first edge closes the polygon: its previous vertex is the last in use.
   always_comb begin
      head_tok    = '0;
      head_tok.cx = cx;
      head_tok.cy = cy;
      head_tok.px = cell_x[last_idx];
      head_tok.py = cell_y[last_idx];
   end

   assign chain_tok[0] = head_tok;
   assign chain_vld[0] = chain_inject;

   for (genvar i = 0; i < bcip_pkg::MAX_VERTICES; i++) begin : g_cell
      bcip_pkg::cell_ctl_type ctl;

      assign ctl.wr = req_acc && is_load && (int'(req_vertex_index) == i);
      assign ctl.en = bcip_pkg::CNT_W'(i) < n_use;
      assign vld_vec[i] = chain_vld[i+1];

      bcip_cell u_cell (
         .clock   (clock),
         .reset   (reset),
         .ctl     (ctl),
         .wr_x    (req_vertex_x),
         .wr_y    (req_vertex_y),
         .in_vld  (chain_vld[i]),
         .in_tok  (chain_tok[i]),
         .out_vld (chain_vld[i+1]),
         .out_tok (chain_tok[i+1]),
         .vx      (cell_x[i]),
         .vy      (cell_y[i])
      );
   end

   // Resolve the edge of the last cell.
   assign last_tok   = chain_tok[bcip_pkg::MAX_VERTICES];
   assign final_flag = last_tok.flag
                     ^ (last_tok.pend && bcip_pkg::edge_cross(last_tok.pneg,
                                                               last_tok.lhs,
                                                               last_tok.rhs));

   // ---------------------------------------------------------------- checks
   a_chain_single: assert property (@(posedge clock) disable iff (reset)
      $onehot0(vld_vec))
      else $error("more than one query in the cell chain");

   a_div_lockstep: assert property (@(posedge clock) disable iff (reset)
      done_x == done_y)
      else $error("center dividers out of step");

   a_chain_in_walk: assert property (@(posedge clock) disable iff (reset)
      chain_vld[bcip_pkg::MAX_VERTICES] |-> (state_ff == bcip_pkg::S_WALK))
      else $error("query left the chain outside the walk phase");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ready) |=> rsp_valid_ff && $stable(rsp_inside_ff))
      else $error("pending response overwritten or dropped");

endmodule

`default_nettype wire

FILE: dv/testbench.sv
// Self-checking testbench for box_center_in_polygon: a directed table, then random phases
// under several frame and vertex-count settings, checked against an in-bench predictor
// or hand-typed expectations. Depends on bcip_pkg and the box_center_in_polygon RTL.
`timescale 1ns / 1ps

module testbench;

   localparam int CYCLE_LIMIT     = 600000;
   localparam int SETTLE_CYCLES   = 40;
   localparam int LONG_HOLD       = 400;
   localparam int NUM_PHASES      = 10;
   localparam int ITEMS_PER_PHASE = 85;
   localparam int MAX_REPORTS     = 10;
   localparam logic [bcip_pkg::CSR_IDX_W-1:0] REG_UNUSED = 2'd3;

   typedef struct packed {
      bcip_pkg::opcode_type               op;
      logic [bcip_pkg::VIDX_W-1:0]        slot;
      logic [bcip_pkg::COORD_W-1:0]       vx;
      logic [bcip_pkg::COORD_W-1:0]       vy;
      logic [bcip_pkg::PIX_W-1:0]         bx;
      logic [bcip_pkg::PIX_W-1:0]         by;
      logic [bcip_pkg::PIX_W-1:0]         bw;
      logic [bcip_pkg::PIX_W-1:0]         bh;
   } zone_req_type;

   typedef struct {
      bit                                 is_csr;
      logic [bcip_pkg::CSR_IDX_W-1:0]     reg_idx;
      logic [bcip_pkg::CSR_DATA_W-1:0]    reg_val;
      zone_req_type                       item;
      bit                                 has_typed;
      bit                                 typed_inside;
   } directed_row_type;

   logic                               clock;
   logic                               reset;
   logic                               req_valid;
   logic                               req_ready;
   logic                               req_opcode;
   logic [bcip_pkg::VIDX_W-1:0]        req_vertex_index;
   logic [bcip_pkg::COORD_W-1:0]       req_vertex_x;
   logic [bcip_pkg::COORD_W-1:0]       req_vertex_y;
   logic [bcip_pkg::PIX_W-1:0]         req_box_x;
   logic [bcip_pkg::PIX_W-1:0]         req_box_y;
   logic [bcip_pkg::PIX_W-1:0]         req_box_w;
   logic [bcip_pkg::PIX_W-1:0]         req_box_h;
   logic                               rsp_valid;
   logic                               rsp_ready;
   logic                               rsp_inside_res;
   logic                               csr_wr_en;
   logic [bcip_pkg::CSR_IDX_W-1:0]     csr_index;
   logic [bcip_pkg::CSR_DATA_W-1:0]    csr_wdata;

   // travels with the payload: a hand-typed expectation for directed rows
   logic                   row_has_typed;
   logic                   row_typed_val;

   box_center_in_polygon dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_opcode       (req_opcode),
      .req_vertex_index (req_vertex_index),
      .req_vertex_x     (req_vertex_x),
      .req_vertex_y     (req_vertex_y),
      .req_box_x        (req_box_x),
      .req_box_y        (req_box_y),
      .req_box_w        (req_box_w),
      .req_box_h        (req_box_h),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_inside_res   (rsp_inside_res),
      .csr_wr_en        (csr_wr_en),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   // predictor state
   logic [bcip_pkg::PIX_W-1:0]    frame_w;
   logic [bcip_pkg::PIX_W-1:0]    frame_h;
   logic [bcip_pkg::VCNT_W-1:0]   zone_count;
   logic [bcip_pkg::COORD_W-1:0]  zone_x [bcip_pkg::MAX_VERTICES];
   logic [bcip_pkg::COORD_W-1:0]  zone_y [bcip_pkg::MAX_VERTICES];

   bit                 inside_expect_q [$];
   directed_row_type   directed_rows [$];

   int   mismatches = 0;
   int   n_loads = 0;
   int   n_queries = 0;
   int   n_inside = 0;
   int   n_settings = 0;
   int   cycle_count = 0;
   int   burst_left = 0;
   bit   long_hold_req = 0;
   bit   long_hold_done = 0;

   int   preset_w [7] = '{640, 1, 8191, 1920, 8191, 0, 320};
   int   preset_h [7] = '{480, 1, 8191, 1080, 1, 720, 240};
   int   preset_n [7] = '{4, 3, 16, 31, 5, 8, 2};

   initial clock = 1'b0;
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results outstanding",
                  cycle_count, inside_expect_q.size());
         $display("box_center_in_polygon regression: fail");
         $finish;
      end
   end

   // Even-odd crossing test of the box center against the loaded zone.
   function automatic bit zone_contains_center(input logic [bcip_pkg::PIX_W-1:0] bx,
                                               input logic [bcip_pkg::PIX_W-1:0] by,
                                               input logic [bcip_pkg::PIX_W-1:0] bw,
                                               input logic [bcip_pkg::PIX_W-1:0] bh);
      longint cx, cy, xi, yi, xj, yj, dy, lhs, rhs;
      int     n, i, j;
      bit     flag;
      n = (int'(zone_count) > bcip_pkg::MAX_VERTICES) ? bcip_pkg::MAX_VERTICES
                                                      : int'(zone_count);
      if (n < bcip_pkg::MIN_VERTS || frame_w == '0 || frame_h == '0)
         return 1'b0;
      cx = ((2 * longint'(bx) + longint'(bw)) << bcip_pkg::FRACTION_BITS)
         / (2 * longint'(frame_w));
      cy = ((2 * longint'(by) + longint'(bh)) << bcip_pkg::FRACTION_BITS)
         / (2 * longint'(frame_h));
      flag = 1'b0;
      j = n - 1;
      for (i = 0; i < n; i++) begin
         xi = longint'(zone_x[i]);
         yi = longint'(zone_y[i]);
         xj = longint'(zone_x[j]);
         yj = longint'(zone_y[j]);
         if ((yi > cy) != (yj > cy)) begin
            dy  = yj - yi;
            lhs = (cx - xi) * dy;
            rhs = (xj - xi) * (cy - yi);
            // the sign of dy decides which way the cross-multiplied compare points
            if ((dy > 0) ? (lhs < rhs) : (lhs > rhs))
               flag = !flag;
         end
         j = i;
      end
      return flag;
   endfunction

   function automatic zone_req_type make_query(input int bx, input int by, input int bw,
                                               input int bh);
      zone_req_type it;
      it.op   = bcip_pkg::OP_QUERY;
      it.slot = bcip_pkg::VIDX_W'($urandom);
      it.vx   = bcip_pkg::COORD_W'($urandom);
      it.vy   = bcip_pkg::COORD_W'($urandom);
      it.bx   = bcip_pkg::PIX_W'(bx);
      it.by   = bcip_pkg::PIX_W'(by);
      it.bw   = bcip_pkg::PIX_W'(bw);
      it.bh   = bcip_pkg::PIX_W'(bh);
      return it;
   endfunction

   function automatic zone_req_type make_load(input int slot, input int vx, input int vy);
      zone_req_type it;
      it.op   = bcip_pkg::OP_LOAD;
      it.slot = bcip_pkg::VIDX_W'(slot);
      it.vx   = bcip_pkg::COORD_W'(vx);
      it.vy   = bcip_pkg::COORD_W'(vy);
      it.bx   = bcip_pkg::PIX_W'($urandom);
      it.by   = bcip_pkg::PIX_W'($urandom);
      it.bw   = bcip_pkg::PIX_W'($urandom);
      it.bh   = bcip_pkg::PIX_W'($urandom);
      return it;
   endfunction

   function automatic void push_csr(input logic [bcip_pkg::CSR_IDX_W-1:0] idx,
                                    input int val);
      directed_row_type row;
      row = '{default: '0};
      row.is_csr  = 1'b1;
      row.reg_idx = idx;
      row.reg_val = bcip_pkg::CSR_DATA_W'(val);
      directed_rows.insert(directed_rows.size(), row);
   endfunction

   function automatic void push_item(input zone_req_type it, input bit has_typed,
                                     input bit typed_inside);
      directed_row_type row;
      row = '{default: '0};
      row.item         = it;
      row.has_typed    = has_typed;
      row.typed_inside = typed_inside;
      directed_rows.insert(directed_rows.size(), row);
   endfunction

   // Offer one transaction; called at a falling edge, returns at a falling edge.
   task automatic offer_item(input zone_req_type it, input bit has_typed,
                             input bit typed_val);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : int'($urandom_range(1, 12));
         burst_left = $urandom_range(1, 24);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
      burst_left--;
      req_valid        <= 1'b1;
      req_opcode       <= it.op;
      req_vertex_index <= it.slot;
      req_vertex_x     <= it.vx;
      req_vertex_y     <= it.vy;
      req_box_x        <= it.bx;
      req_box_y        <= it.by;
      req_box_w        <= it.bw;
      req_box_h        <= it.bh;
      row_has_typed    <= has_typed;
      row_typed_val    <= typed_val;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
   endtask

   // Hold the sender until every response is back and the block has settled.
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (inside_expect_q.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_reg(input logic [bcip_pkg::CSR_IDX_W-1:0] idx, input int val);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= bcip_pkg::CSR_DATA_W'(val);
      @(negedge clock);
      csr_wr_en <= 1'b0;
      @(negedge clock);
   endtask

   // Receiver: random stall modes, plus one long hold-off on request.
   initial begin : receiver
      int mode;
      int mode_left;
      int hold_left;
      mode = 0;
      mode_left = 0;
      hold_left = 0;
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_left > 0) begin
            rsp_ready <= 1'b0;
            hold_left--;
            if (hold_left == 0)
               long_hold_done = 1'b1;
         end else if (long_hold_req && !long_hold_done) begin
            rsp_ready <= 1'b0;
            hold_left = LONG_HOLD;
         end else begin
            if (mode_left == 0) begin
               mode = $urandom_range(0, 3);
               mode_left = $urandom_range(16, 160);
            end
            mode_left--;
            case (mode)
               0: rsp_ready <= 1'b1;
               1: rsp_ready <= 1'($urandom_range(0, 1));
               2: rsp_ready <= ($urandom_range(0, 3) == 0);
               default: rsp_ready <= ((mode_left % 8) < 3);
            endcase
         end
      end
   end

   // Track configuration and loads, expect a result per accepted query, check every response.
   always @(posedge clock) begin : scoreboard
      bit exp_inside;
      if (!reset) begin
         if (csr_wr_en) begin
            case (csr_index)
               bcip_pkg::REG_FRAME_WIDTH:  frame_w    = csr_wdata;
               bcip_pkg::REG_FRAME_HEIGHT: frame_h    = csr_wdata;
               bcip_pkg::REG_VERTEX_COUNT: zone_count = csr_wdata[bcip_pkg::VCNT_W-1:0];
               default: ;  // drop writes to unknown registers
            endcase
         end
         if (req_valid && req_ready) begin
            if (req_opcode == bcip_pkg::OP_LOAD) begin
               zone_x[req_vertex_index] = req_vertex_x;
               zone_y[req_vertex_index] = req_vertex_y;
               n_loads++;
            end else begin
               exp_inside = row_has_typed ? row_typed_val
                  : zone_contains_center(req_box_x, req_box_y, req_box_w, req_box_h);
               inside_expect_q.insert(inside_expect_q.size(), exp_inside);
               n_queries++;
            end
         end
         if (rsp_valid === 1'b1 && rsp_ready) begin
            if (inside_expect_q.size() == 0) begin
               mismatches++;
               if (mismatches <= MAX_REPORTS)
                  $display("unexpected response inside_res=%b at cycle %0d",
                           rsp_inside_res, cycle_count);
            end else begin
               exp_inside = inside_expect_q.pop_front();
               if (rsp_inside_res !== exp_inside) begin
                  mismatches++;
                  if (mismatches <= MAX_REPORTS)
                     $display("inside_res mismatch at cycle %0d: expected %b, got %b",
                              cycle_count, exp_inside, rsp_inside_res);
               end
               if (rsp_inside_res === 1'b1)
                  n_inside++;
            end
         end
      end
   end

   initial begin : stimulus
      zone_req_type  it;
      bit            last_csr;
      int            p, k, s, fw, fh, vc, n_used;
      int            bx, by, bw, bh;

      reset            = 1'b1;
      req_valid        = 1'b0;
      req_opcode       = bcip_pkg::OP_LOAD;
      req_vertex_index = '0;
      req_vertex_x     = '0;
      req_vertex_y     = '0;
      req_box_x        = '0;
      req_box_y        = '0;
      req_box_w        = '0;
      req_box_h        = '0;
      csr_wr_en        = 1'b0;
      csr_index        = '0;
      csr_wdata        = '0;
      row_has_typed    = 1'b0;
      row_typed_val    = 1'b0;
      frame_w          = '0;
      frame_h          = '0;
      zone_count       = '0;
      foreach (zone_x[i]) begin
         zone_x[i] = '0;
         zone_y[i] = '0;
      end

      // directed table: registers at reset, a square in slots 0..3,
      // then the zero-size, short-count, saturated-count and unknown-index cases
      push_item(make_query(8191, 8191, 8191, 8191), 1'b1, 1'b0);
      push_item(make_load(0, 16384, 16384), 1'b0, 1'b0);
      push_item(make_load(1, 49152, 16384), 1'b0, 1'b0);
      push_item(make_load(2, 49152, 49152), 1'b0, 1'b0);
      push_item(make_load(3, 16384, 49152), 1'b0, 1'b0);
      push_item(make_load(4, 0, 65535), 1'b0, 1'b0);
      push_item(make_load(5, 65535, 0), 1'b0, 1'b0);
      for (s = 6; s < bcip_pkg::MAX_VERTICES; s++)
         push_item(make_load(s, s * 4000, 65535 - s * 3000), 1'b0, 1'b0);
      push_csr(bcip_pkg::REG_FRAME_WIDTH, 100);
      push_csr(bcip_pkg::REG_FRAME_HEIGHT, 100);
      push_csr(bcip_pkg::REG_VERTEX_COUNT, 4);
      push_item(make_query(40, 40, 20, 20), 1'b1, 1'b1);
      push_item(make_query(0, 0, 0, 0), 1'b1, 1'b0);
      push_item(make_query(8191, 8191, 8191, 8191), 1'b1, 1'b0);
      push_csr(bcip_pkg::REG_VERTEX_COUNT, 2);
      push_item(make_query(40, 40, 20, 20), 1'b1, 1'b0);
      push_csr(bcip_pkg::REG_VERTEX_COUNT, 4);
      push_csr(REG_UNUSED, 8191);
      push_item(make_query(40, 40, 20, 20), 1'b1, 1'b1);
      push_csr(bcip_pkg::REG_FRAME_WIDTH, 0);
      push_item(make_query(40, 40, 20, 20), 1'b1, 1'b0);
      push_csr(bcip_pkg::REG_FRAME_WIDTH, 8191);
      push_csr(bcip_pkg::REG_FRAME_HEIGHT, 0);
      push_item(make_query(40, 40, 20, 20), 1'b1, 1'b0);
      push_csr(bcip_pkg::REG_FRAME_WIDTH, 1);
      push_csr(bcip_pkg::REG_FRAME_HEIGHT, 1);
      push_item(make_query(0, 0, 1, 1), 1'b1, 1'b1);
      push_csr(bcip_pkg::REG_VERTEX_COUNT, 31);
      push_item(make_query(0, 0, 1, 1), 1'b0, 1'b0);
      push_csr(bcip_pkg::REG_VERTEX_COUNT, 3);
      push_item(make_query(0, 0, 1, 1), 1'b0, 1'b0);

      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      last_csr = 1'b0;
      foreach (directed_rows[r]) begin
         if (directed_rows[r].is_csr) begin
            if (!last_csr)
               wait_idle();
            write_reg(directed_rows[r].reg_idx, int'(directed_rows[r].reg_val));
            last_csr = 1'b1;
         end else begin
            offer_item(directed_rows[r].item, directed_rows[r].has_typed,
                       directed_rows[r].typed_inside);
            last_csr = 1'b0;
         end
      end

      for (p = 0; p < NUM_PHASES; p++) begin
         if (p < 7) begin
            fw = preset_w[p];
            fh = preset_h[p];
            vc = preset_n[p];
         end else begin
            fw = $urandom_range(1, 8191);
            fh = $urandom_range(1, 8191);
            vc = $urandom_range(3, 16);
         end
         wait_idle();
         write_reg(bcip_pkg::REG_FRAME_WIDTH, fw);
         write_reg(bcip_pkg::REG_FRAME_HEIGHT, fh);
         // junk in the upper data bits must not reach the count
         write_reg(bcip_pkg::REG_VERTEX_COUNT,
                   int'(($urandom_range(0, 255) << bcip_pkg::VCNT_W) | vc));
         if (p % 3 == 0)
            write_reg(REG_UNUSED, $urandom_range(0, 8191));
         n_settings++;
         if (p == 3)
            long_hold_req = 1'b1;

         n_used = (vc > bcip_pkg::MAX_VERTICES) ? bcip_pkg::MAX_VERTICES : vc;
         for (s = 0; s < n_used; s++)
            offer_item(make_load(s, $urandom_range(0, 65535), $urandom_range(0, 65535)),
                       1'b0, 1'b0);

         for (k = 0; k < ITEMS_PER_PHASE; k++) begin
            if ($urandom_range(0, 99) < 12) begin
               it = make_load($urandom_range(0, bcip_pkg::MAX_VERTICES - 1),
                              $urandom_range(0, 65535), $urandom_range(0, 65535));
            end else if (fw != 0 && fh != 0 && $urandom_range(0, 9) < 8) begin
               // center mostly inside the frame so both flag values show up
               bx = $urandom_range(0, fw - 1);
               by = $urandom_range(0, fh - 1);
               bw = $urandom_range(0, 15);
               bh = $urandom_range(0, 15);
               it = make_query(bx, by, bw, bh);
            end else begin
               it = make_query($urandom_range(0, 8191), $urandom_range(0, 8191),
                               $urandom_range(0, 8191), $urandom_range(0, 8191));
            end
            offer_item(it, 1'b0, 1'b0);
         end
      end

      wait_idle();
      $display("ran %0d vertex loads and %0d queries (%0d inside) over %0d random settings",
               n_loads, n_queries, n_inside, n_settings);
      $display("%0d mismatches in %0d cycles", mismatches, cycle_count);
      if (mismatches == 0 && inside_expect_q.size() == 0)
         $display("box_center_in_polygon regression: pass");
      else
         $display("box_center_in_polygon regression: fail");
      $finish;
   end

endmodule
